// ----- sv/kdvls_pkg.sv -----
`default_nettype none

package kdvls_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int COEFF_W     = 32;
   localparam int WIN_DEPTH   = 5;
   localparam int OLD_DEPTH   = 3;
   localparam int ACC_W       = 98;
   localparam int ADV_SHIFT   = 54;
   localparam int ADV_W       = 45;
   localparam int DISP_PROD_W = 66;
   localparam int DISP_SHIFT  = 30;
   localparam int DISP_W      = 38;
   localparam int RES_W       = 46;

   // window slot of the newest sample
   localparam logic [2:0] POS_NEWEST = 3'd4;

   // configuration register indexes
   localparam logic [0:0] REG_ADVECT   = 1'b0;
   localparam logic [0:0] REG_DISPERSE = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // stencil operands in sign-magnitude form
   typedef struct packed {
      logic        sum_neg;
      logic [32:0] sum_mag;
      logic        diff_neg;
      logic [31:0] diff_mag;
      logic        sten_neg;
      logic [33:0] sten_mag;
   } operand_type;

   // one multiply issue: accumulate, clear first, shift in 32-bit limbs
   typedef struct packed {
      logic       issue;
      logic       clr;
      logic [1:0] shift;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ----- sv/kdvls_mac.sv -----
`default_nettype none

module kdvls_mac
   import kdvls_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mac_ctl_type       ctl,
   input  wire logic [31:0]       op_a,
   input  wire logic [31:0]       op_b,
   output logic      [ACC_W-1:0]  acc
);

   logic [63:0]      prod_ff;
   mac_ctl_type      tag_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [ACC_W-1:0] addend;

   always_comb begin
      addend = ACC_W'(prod_ff) << {tag_ff.shift, 5'b00000};
      acc_in = acc_ff;
      if (tag_ff.issue) begin
         acc_in = (tag_ff.clr ? {ACC_W{1'b0}} : acc_ff) + addend;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= ctl;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ----- sv/kdvls_stencil.sv -----
`default_nettype none

module kdvls_stencil
   import kdvls_pkg::*;
(
   input  wire sample_type  win [WIN_DEPTH],
   input  wire logic [2:0]  center_pos,
   input  wire logic [2:0]  low_pos,
   output operand_type      ops
);

   logic [3:0]         raw [WIN_DEPTH];
   logic [2:0]         pos [WIN_DEPTH];
   sample_type         tap [WIN_DEPTH];
   logic signed [33:0] sum;
   logic signed [32:0] diff;
   logic signed [34:0] sten;

   // clamp each neighbor to the row ends
   always_comb begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         raw[k] = 4'({1'b0, center_pos}) + 4'(k) - 4'd2;
         if (raw[k] > {1'b0, POS_NEWEST}) begin
            pos[k] = POS_NEWEST;
         end else if (raw[k] < {1'b0, low_pos}) begin
            pos[k] = low_pos;
         end else begin
            pos[k] = raw[k][2:0];
         end
         tap[k] = win[pos[k]];
      end
   end

   always_comb begin
      sum  = 34'(tap[3]) + 34'(tap[2]) + 34'(tap[1]);
      diff = 33'(tap[3]) - 33'(tap[1]);
      sten = 35'(tap[4]) - (35'(tap[3]) <<< 1) + (35'(tap[1]) <<< 1) - 35'(tap[0]);
      ops.sum_neg  = sum[33];
      ops.sum_mag  = 33'(sum[33] ? -sum : sum);
      ops.diff_neg = diff[32];
      ops.diff_mag = 32'(diff[32] ? -diff : diff);
      ops.sten_neg = sten[34];
      ops.sten_mag = 34'(sten[34] ? -sten : sten);
   end

endmodule

`default_nettype wire

// ----- sv/kdv_leapfrog_stencil.sv -----
// each result steps through operand setup, seven 32x32 partial products with two waits
// and a final add/saturate; the finish step stalls while the output slot is still full
// a new point is accepted only while idle, never while a result is being worked
// all products go through the single shared 32x32 multiply-accumulate unit
// reset: synchronous, active high; clears sequencer, row counter, output valid and coeffs
`default_nettype none

module kdv_leapfrog_stencil
   import kdvls_pkg::*;
#(
   parameter int MAX_POINTS = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // cur_sample [31:0], old_sample [63:32]
   input  wire logic        req_tlast,   // row_end
   // result beats
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // new_sample [31:0]
   output logic             rsp_tlast,   // row_done
   // coefficient writes
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_POINTS);
   localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(MAX_POINTS - 1);
   // window slot of the point being produced: two back, one back, newest
   localparam logic [2:0] R_FIRST = 3'd2;
   localparam logic [2:0] R_MID   = 3'd3;
   localparam logic [2:0] R_LAST  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_M0,
      ST_M1,
      ST_W1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_W2,
      ST_FIN
   } state_type;

   state_type               state_ff;
   sample_type              win_ff [WIN_DEPTH];
   sample_type              od_ff  [OLD_DEPTH];
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        i_ff;
   logic                    last_ff;
   logic [2:0]              r_ff;
   operand_type             ops_ff;
   sample_type              old_ff;
   logic                    edge_ff;
   logic [32:0]             x_ff;
   logic signed [ADV_W-1:0] adv_ff;
   logic [COEFF_W-1:0]      advect_ff;
   logic [COEFF_W-1:0]      disperse_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_data_ff;
   logic                    rsp_last_ff;

   operand_type              ops;
   logic [2:0]               low_pos;
   logic                     row_last;
   logic                     edge_in;
   mac_ctl_type              mac_ctl;
   logic [31:0]              mac_a;
   logic [31:0]              mac_b;
   logic [ACC_W-1:0]         acc;
   logic                     adv_sticky;
   logic signed [ADV_W-1:0]  adv_in;
   logic                     disp_sticky;
   logic signed [DISP_W-1:0] disp_val;
   logic signed [RES_W-1:0]  res_wide;
   logic [31:0]              res_sat;

   // lowest window slot still inside the current row
   assign low_pos  = (i_ff >= CNT_W'(4)) ? 3'd0 : 3'd4 - i_ff[2:0];
   assign row_last = req_tlast || (cnt_ff == LAST_INDEX);
   // first point of the row sits at slot 4 - i, last point at slot 4
   assign edge_in  = (r_ff == R_LAST) ||
                     ((i_ff < CNT_W'(4)) && (3'(i_ff[2:0] + r_ff) == R_LAST));

   kdvls_stencil u_stencil (
      .win        (win_ff),
      .center_pos (r_ff),
      .low_pos    (low_pos),
      .ops        (ops)
   );

   // partial product schedule:
   //   m0/m1  |sum| * |diff|  (p1, 65 bits)
   //   m2..m4 p1 * advect     (p2, 97 bits)
   //   m5/m6  |sten| * disperse
   always_comb begin
      mac_ctl = '0;
      mac_a   = '0;
      mac_b   = '0;
      case (state_ff)
         ST_M0: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, shift: 2'd0};
            mac_a   = ops_ff.diff_mag;
            mac_b   = ops_ff.sum_mag[31:0];
         end
         ST_M1: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, shift: 2'd1};
            mac_a   = ops_ff.diff_mag;
            mac_b   = {31'b0, ops_ff.sum_mag[32]};
         end
         ST_M2: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, shift: 2'd0};
            mac_a   = acc[31:0];
            mac_b   = advect_ff;
         end
         ST_M3: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, shift: 2'd1};
            mac_a   = x_ff[31:0];
            mac_b   = advect_ff;
         end
         ST_M4: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, shift: 2'd2};
            mac_a   = {31'b0, x_ff[32]};
            mac_b   = advect_ff;
         end
         ST_M5: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, shift: 2'd0};
            mac_a   = ops_ff.sten_mag[31:0];
            mac_b   = disperse_ff;
         end
         ST_M6: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, shift: 2'd1};
            mac_a   = {30'b0, ops_ff.sten_mag[33:32]};
            mac_b   = disperse_ff;
         end
         default: begin
            mac_ctl = '0;
         end
      endcase
   end

   kdvls_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   // advection term: floor of signed p2 / 2^54
   always_comb begin
      adv_sticky = |acc[ADV_SHIFT-1:0];
      if (ops_ff.sum_neg ^ ops_ff.diff_neg) begin
         adv_in = -(ADV_W'(acc[ACC_W-1:ADV_SHIFT]) + ADV_W'(adv_sticky));
      end else begin
         adv_in = ADV_W'(acc[ACC_W-1:ADV_SHIFT]);
      end
   end

   // dispersion term: floor of signed product / 2^30, then old + adv - disp
   always_comb begin
      disp_sticky = |acc[DISP_SHIFT-1:0];
      if (ops_ff.sten_neg) begin
         disp_val = -(DISP_W'(acc[DISP_PROD_W-1:DISP_SHIFT]) + DISP_W'(disp_sticky));
      end else begin
         disp_val = DISP_W'(acc[DISP_PROD_W-1:DISP_SHIFT]);
      end
      res_wide = RES_W'(old_ff) + RES_W'(adv_ff) - RES_W'(disp_val);
      if (!res_wide[RES_W-1] && (|res_wide[RES_W-2:31])) begin
         res_sat = 32'h7fff_ffff;
      end else if (res_wide[RES_W-1] && !(&res_wide[RES_W-2:31])) begin
         res_sat = 32'h8000_0000;
      end else begin
         res_sat = res_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         advect_ff    <= '0;
         disperse_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_ADVECT:   advect_ff   <= csr_wdata;
               REG_DISPERSE: disperse_ff <= csr_wdata;
               default:      advect_ff   <= advect_ff;
            endcase
         end

         // output slot loads from the finish step, drains on a taken beat
         if ((state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                     win_ff[k] <= win_ff[k+1];
                  end
                  win_ff[WIN_DEPTH-1] <= req_tdata[31:0];
                  for (int k = 0; k < OLD_DEPTH - 1; k++) begin
                     od_ff[k] <= od_ff[k+1];
                  end
                  od_ff[OLD_DEPTH-1] <= req_tdata[63:32];
                  i_ff    <= cnt_ff;
                  last_ff <= row_last;
                  if (row_last) begin
                     // flush up to three results for the tail of the row
                     cnt_ff   <= '0;
                     state_ff <= ST_SETUP;
                     if (cnt_ff >= CNT_W'(2)) begin
                        r_ff <= R_FIRST;
                     end else if (cnt_ff == CNT_W'(1)) begin
                        r_ff <= R_MID;
                     end else begin
                        r_ff <= R_LAST;
                     end
                  end else begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                     if (cnt_ff >= CNT_W'(2)) begin
                        r_ff     <= R_FIRST;
                        state_ff <= ST_SETUP;
                     end
                  end
               end
            end
            ST_SETUP: begin
               ops_ff   <= ops;
               old_ff   <= od_ff[2'(r_ff - R_FIRST)];
               edge_ff  <= edge_in;
               state_ff <= ST_M0;
            end
            ST_M0: state_ff <= ST_M1;
            ST_M1: state_ff <= ST_W1;
            ST_W1: state_ff <= ST_M2;
            ST_M2: begin
               x_ff     <= acc[64:32];
               state_ff <= ST_M3;
            end
            ST_M3: state_ff <= ST_M4;
            ST_M4: state_ff <= ST_M5;
            ST_M5: state_ff <= ST_M6;
            ST_M6: begin
               adv_ff   <= adv_in;
               state_ff <= ST_W2;
            end
            ST_W2: state_ff <= ST_FIN;
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= edge_ff ? 32'h0 : res_sat;
                  rsp_last_ff  <= last_ff && (r_ff == R_LAST);
                  if (last_ff && (r_ff != R_LAST)) begin
                     r_ff     <= r_ff + 3'd1;
                     state_ff <= ST_SETUP;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // the multiplier is only driven while a point is being worked
   a_idle_no_issue : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mac_ctl.issue)
      else $error("multiply issued while idle");

   // the first two points of a row produce nothing and leave the block ready
   a_head_no_work : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast && (cnt_ff < CNT_W'(2))) |=> req_tready)
      else $error("busy after a head-of-row beat");

   // result slot stays within the window
   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((r_ff >= R_FIRST) && (r_ff <= R_LAST)))
      else $error("result slot out of range");
`endif

endmodule

`default_nettype wire

// ----- sim/kdv_leapfrog_stencil_tb.sv -----
module kdv_leapfrog_stencil_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kdvls_pkg::*;

   // row length cap of the block, left at its default
   localparam int ROW_CAP       = 4096;
   // quiet cycles with no beat on either side before the run is called hung
   localparam int STALL_LIMIT   = 2000;
   // cycles the result side holds off during the pressure test
   localparam int HOLD_CYCLES   = 300;
   // a point with no result may still be in flight when the last result lands
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 40;

   localparam sample_type SAMPLE_MAX = 32'sh7fff_ffff;
   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [127:0] SAT_HI = 128'sh7fff_ffff;
   localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;
   localparam logic [31:0] UNIT_Q2_30 = 32'h4000_0000;

   // one expected next-row sample
   typedef struct {
      logic [31:0] value;
      logic        done;
   } u_next_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // cur_sample [31:0], old_sample [63:32]
   logic        req_tlast  = 1'b0; // row_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // new_sample [31:0]
   logic        rsp_tlast;         // row_done
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_addr   = REG_ADVECT;
   logic [31:0] csr_wdata  = '0;

   kdv_leapfrog_stencil #(
      .MAX_POINTS(ROW_CAP)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // predictor state: coefficients, u(n) window, u(n-1) delay, point index
   logic [31:0] adv_weight  = '0;
   logic [31:0] disp_weight = '0;
   sample_type  row_win[WIN_DEPTH];
   sample_type  old_win[OLD_DEPTH];
   int          pt_idx = 0;

   // next-row samples still owed by the block, oldest first
   u_next_type  due_points[$];

   // pacing knobs, percent of cycles each side sits out
   int          sender_idle_pct   = 0;
   int          receiver_idle_pct = 0;
   bit          hold_request      = 1'b0;

   int          errors       = 0;
   int          points_sent  = 0;
   int          rows_sent    = 0;
   int          results_seen = 0;
   int          coeff_sets   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < WIN_DEPTH; k++) row_win[k] = '0;
      for (int k = 0; k < OLD_DEPTH; k++) old_win[k] = '0;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // u(n) at point k, clamped to the row ends; window slot 4 holds point i
   function automatic logic signed [127:0] u_at(int k, int i, int last_idx);
      if (k < 0)
         k = 0;
      if (k > last_idx)
         k = last_idx;
      return row_win[(k - i + int'(POS_NEWEST)) & 7];
   endfunction

   // u(n+1) at point j once point i (the row's last so far) has arrived
   function automatic logic [31:0] leapfrog_point(int j, int i, int last_idx);
      logic signed [127:0] um2, um1, u0, up1, up2;
      logic signed [127:0] nsum, ndiff, sten, a_w, d_w, adv, disp, u_old, acc;
      // edge points are pinned to zero
      if (j == 0 || j == last_idx)
         return '0;
      um2   = u_at(j - 2, i, last_idx);
      um1   = u_at(j - 1, i, last_idx);
      u0    = u_at(j, i, last_idx);
      up1   = u_at(j + 1, i, last_idx);
      up2   = u_at(j + 2, i, last_idx);
      u_old = old_win[(j - i + 2) & 3];
      nsum  = up1 + u0 + um1;
      ndiff = up1 - um1;
      sten  = up2 - 2 * up1 + 2 * um1 - um2;
      a_w   = {96'd0, adv_weight};
      d_w   = {96'd0, disp_weight};
      // arithmetic shift of a signed value floors toward minus infinity
      adv   = (a_w * nsum * ndiff) >>> ADV_SHIFT;
      disp  = (d_w * sten) >>> DISP_SHIFT;
      acc   = u_old + adv - disp;
      if (acc > SAT_HI)
         return 32'h7fff_ffff;
      if (acc < SAT_LO)
         return 32'h8000_0000;
      return acc[31:0];
   endfunction

   // take one accepted point into the predictor and queue what it releases
   task automatic absorb_point(sample_type cur, sample_type old, logic row_end);
      int i;
      bit last;
      i = pt_idx;
      for (int k = 0; k < WIN_DEPTH - 1; k++) row_win[k] = row_win[k + 1];
      row_win[WIN_DEPTH - 1] = cur;
      for (int k = 0; k < OLD_DEPTH - 1; k++) old_win[k] = old_win[k + 1];
      old_win[OLD_DEPTH - 1] = old;
      // an overlong row is cut at the cap whatever tlast says
      last = row_end || (i >= ROW_CAP - 1);
      if (!last) begin
         if (i >= 2)
            due_points.push_back('{leapfrog_point(i - 2, i, i), 1'b0});
         pt_idx = i + 1;
      end else begin
         // row end flushes up to three points
         for (int j = (i >= 2) ? i - 2 : 0; j <= i; j++)
            due_points.push_back('{leapfrog_point(j, i, i), j == i});
         pt_idx = 0;
         rows_sent++;
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic sample_type pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      // mostly physical amplitudes within +-8.0, then full range, then corners
      if (r < 55)
         return sample_type'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
      if (r < 88)
         return sample_type'($urandom);
      case ($urandom_range(0, 4))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic logic [31:0] pick_coeff();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 20)
         return '1;
      if (r < 30)
         return UNIT_Q2_30;
      if (r < 70)
         return $urandom_range(0, 32'h1000_0000);
      return $urandom;
   endfunction

   // offer one point, with random gaps in front of it, and wait for the beat
   task automatic send_point(sample_type cur, sample_type old, logic row_end);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {old, cur};
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      absorb_point(cur, old, row_end);
      points_sent++;
   endtask

   // stop offering, let every owed result come home, then let the pipe settle
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // coefficient writes happen only with the block idle
   task automatic set_coeffs(logic [31:0] adv_c, logic [31:0] disp_c);
      drain_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_ADVECT;
      csr_wdata <= adv_c;
      @(negedge clock);
      csr_addr  <= REG_DISPERSE;
      csr_wdata <= disp_c;
      @(negedge clock);
      csr_we    <= 1'b0;
      adv_weight  = adv_c;
      disp_weight = disp_c;
      coeff_sets++;
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // rows of one to four points, with the coefficients still at reset
   task automatic test_short_rows();
      for (int len = 1; len <= 4; len++)
         for (int p = 0; p < len; p++)
            send_point(pick_sample(), pick_sample(), p == len - 1);
   endtask

   // field corners with both weights at full scale, driving saturation both ways
   task automatic test_field_extremes();
      sample_type cur_v[7];
      sample_type old_v[7];
      cur_v = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0, -1, SAMPLE_MAX};
      old_v = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1, SAMPLE_MAX, SAMPLE_MIN};
      set_coeffs('1, '1);
      for (int p = 0; p < 7; p++)
         send_point(cur_v[p], old_v[p], p == 6);
   endtask

   // advection weight of one, no dispersion, smooth ramp
   task automatic test_unit_coeffs();
      set_coeffs(UNIT_Q2_30, '0);
      for (int p = 0; p < 6; p++)
         send_point(sample_type'(p * 32'h0080_0000) - 32'sh0100_0000,
                    sample_type'(p) <<< 20, p == 5);
   endtask

   // whole rows of random length and content under fresh weights
   task automatic test_random_rows(int n_points);
      int sent;
      int len;
      int unsigned r;
      sent = 0;
      set_coeffs(pick_coeff(), pick_coeff());
      while (sent < n_points) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            len = $urandom_range(1, 4);
         else if (r < 90)
            len = $urandom_range(5, 24);
         else
            len = $urandom_range(25, 64);
         for (int p = 0; p < len; p++)
            send_point(pick_sample(), pick_sample(), p == len - 1);
         sent += len;
      end
   endtask

   // result side holds off while points keep coming, so the input backs up
   task automatic test_output_hold();
      set_coeffs(pick_coeff(), pick_coeff());
      hold_request = 1'b1;
      for (int row = 0; row < 3; row++)
         for (int p = 0; p < 12; p++)
            send_point(pick_sample(), pick_sample(), p == 11);
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // ready pattern, with a long hold-off on request
   initial begin : result_sink
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            held = HOLD_CYCLES;
         end
         if (held > 0) begin
            held--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // compare each result beat with the oldest owed point
   initial begin : result_check
      u_next_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (due_points.size() == 0) begin
               $error("result beat with nothing owed: new_sample %h row_done %b",
                      rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = due_points.pop_front();
               results_seen++;
               if (rsp_tdata !== want.value) begin
                  $error("new_sample: expected %h, got %h", want.value, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.done) begin
                  $error("row_done: expected %b, got %b", want.done, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // hang detector: too long with no beat on either side
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: %0d cycles without a beat, %0d results still owed",
               STALL_LIMIT, due_points.size());
      $display("** kdv_leapfrog_stencil: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------

   initial begin : run
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender rarely idle, receiver often stalls
      sender_idle_pct   = 14;
      receiver_idle_pct = 56;
      test_short_rows();
      test_field_extremes();
      test_unit_coeffs();
      test_random_rows(100);

      // sender often idle, receiver rarely stalls
      sender_idle_pct   = 56;
      receiver_idle_pct = 14;
      test_random_rows(100);
      test_output_hold();

      // full rate both ways
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_rows(100);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d input beats in %0d rows, %0d result beats checked",
               points_sent, rows_sent, results_seen);
      $display("%0d weight settings; short rows, corner samples, saturation, output hold-off",
               coeff_sets);
      if (errors == 0)
         $display("** kdv_leapfrog_stencil: PASSED **");
      else
         $display("** kdv_leapfrog_stencil: FAILED **");
      $finish;
   end

endmodule
